[rtl/core/fenwick_prefix_combine_table_macros.svh]
// Assertion macros shared by the prefix-combine table RTL
`ifndef FENWICK_PREFIX_COMBINE_TABLE_MACROS_SVH
`define FENWICK_PREFIX_COMBINE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FPCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define FPCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fpct_pkg.sv]
// Shared constants, codes and types of the prefix-combine table
`default_nettype none

package fpct_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 1024;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int POS_W      = ADDR_W + 1;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 10;
    localparam int CMD_W     = 2;
    localparam int MODE_W    = 2;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Combining operator codes (unused code behaves as sum)
    localparam logic [MODE_W-1:0] OP_SUM = 2'd0;
    localparam logic [MODE_W-1:0] OP_MAX = 2'd1;
    localparam logic [MODE_W-1:0] OP_MIN = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_OP_MODE  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IDENTITY = 1'b1;

    typedef logic signed [DATA_W-1:0] node_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [MODE_W-1:0] op_mode;
        node_t             identity_value;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/core/fpct_if.sv]
// Request and response channel interfaces
`default_nettype none

interface fpct_req_if
    import fpct_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   index;
    node_t              value;

    modport source (output valid, output cmd, output index, output value, input ready);
    modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface fpct_rsp_if
    import fpct_pkg::*;
();
    logic  valid;
    logic  ready;
    node_t prefix_result;

    modport source (output valid, output prefix_result, input ready);
    modport sink   (input valid, input prefix_result, output ready);
endinterface

`default_nettype wire

[rtl/core/fpct_cfg_regs.sv]
// APB configuration registers: operator select and identity value
`default_nettype none

module fpct_cfg_regs
    import fpct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [MODE_W-1:0]    op_mode_reg;
    node_t                identity_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg  <= OP_SUM;
            identity_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OP_MODE:  op_mode_reg  <= pwdata[MODE_W-1:0];
                REG_IDENTITY: identity_reg <= pwdata;
                default:      op_mode_reg  <= op_mode_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_OP_MODE:  prdata = {{(32-MODE_W){1'b0}}, op_mode_reg};
            REG_IDENTITY: prdata = identity_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.op_mode        = op_mode_reg;
    assign cfg.identity_value = identity_reg;

endmodule

`default_nettype wire

[rtl/core/fpct_fold_unit.sv]
// Shared combining unit: wrapping sum, signed max or signed min
`default_nettype none

module fpct_fold_unit
    import fpct_pkg::*;
(
    input  wire logic [MODE_W-1:0] op_mode,
    input  wire node_t             a,
    input  wire node_t             b,
    output node_t                  res
);

    // Ties keep a; the unused operator code adds
    always_comb
    begin
        unique case (op_mode)
            OP_MAX:  res = (a < b) ? b : a;
            OP_MIN:  res = (b < a) ? b : a;
            default: res = a + b;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/fpct_node_mem.sv]
// Tree node memory: one write port, one registered read port
`default_nettype none

module fpct_node_mem
    import fpct_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire node_t             wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output node_t                  rdata_reg
);

    node_t node_mem [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            node_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= node_mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/fenwick_prefix_combine_table.sv]
// Top level: binary indexed tree with selectable combine operator
`default_nettype none
`include "fenwick_prefix_combine_table_macros.svh"

// Binary indexed tree over TABLE_SIZE signed 32-bit nodes, combined by
// wrapping sum, signed max or signed min (op_mode register). After reset the
// block runs a clearing pass that zeroes every node; req.ready stays low
// meanwhile, register writes are taken as ever. One item at a time: an
// update walks the nodes on its upward path, a query walks one node per set
// bit in its index until the result is registered, and a clear sweeps every
// node. The node memory is read once per visited node through one registered
// port, with one shared fold unit working on each returned node. A finished
// query result waits in the output register while later updates and clears
// go ahead; a second query holds its result until the first has been taken.
module fenwick_prefix_combine_table
    import fpct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    fpct_req_if.sink                req,
    fpct_rsp_if.source              rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_UPD,
        S_QRY,
        S_RES
    } state_t;

    function automatic logic [POS_W-1:0] low_bit(input logic [POS_W-1:0] x);
        return x & (~x + POS_W'(1));
    endfunction

    cfg_t              cfg;
    state_t            state_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              pend_reg;
    logic              out_valid_reg;
    node_t             result_reg;
    node_t             val_reg;
    node_t             acc_reg;
    logic [ADDR_W-1:0] node_addr_reg;

    logic              in_fire;
    logic              out_fire;
    logic              res_load;
    logic [31:0]       idx_ext;
    logic              upd_ok;
    logic [31:0]       qry_pos;
    logic [POS_W-1:0]  pos_low;
    logic              pos_done;
    logic              sweep_last;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    node_t             mem_wdata;
    logic              mem_re;
    node_t             mem_rdata;
    node_t             fold_a;
    node_t             fold_b;
    node_t             fold_out;

    // Configuration registers
    fpct_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Node storage
    fpct_node_mem u_mem (
        .clk       (clk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .re        (mem_re),
        .raddr     (pos_reg[ADDR_W-1:0]),
        .rdata_reg (mem_rdata)
    );

    // Shared fold unit: node with value on update, accumulator with node on query
    fpct_fold_unit u_fold (
        .op_mode (cfg.op_mode),
        .a       (fold_a),
        .b       (fold_b),
        .res     (fold_out)
    );

    // Handshakes and index decode
    assign req.ready         = (state_reg == S_IDLE);
    assign in_fire           = req.valid && req.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.prefix_result = result_reg;
    assign out_fire          = rsp.valid && rsp.ready;
    assign res_load          = (state_reg == S_RES) && (!out_valid_reg || out_fire);

    assign idx_ext    = 32'(req.index);
    assign upd_ok     = (idx_ext != 32'd0) && (idx_ext < 32'(TABLE_SIZE));
    assign qry_pos    = (idx_ext > 32'(TABLE_SIZE - 1)) ? 32'(TABLE_SIZE - 1) : idx_ext;
    assign pos_low    = low_bit(pos_reg);
    assign pos_done   = (pos_reg >= POS_W'(TABLE_SIZE));
    assign sweep_last = (pos_reg == POS_W'(TABLE_SIZE - 1));

    // Memory port control
    always_comb
    begin
        mem_re    = ((state_reg == S_UPD) && !pos_done)
                 || ((state_reg == S_QRY) && (pos_reg != '0));
        mem_we    = 1'b0;
        mem_waddr = node_addr_reg;
        mem_wdata = fold_out;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[ADDR_W-1:0];
                mem_wdata = '0;
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[ADDR_W-1:0];
                mem_wdata = cfg.identity_value;
            end
            S_UPD:   mem_we = pend_reg;
            default: mem_we = 1'b0;
        endcase
    end

    assign fold_a = (state_reg == S_UPD) ? mem_rdata : acc_reg;
    assign fold_b = (state_reg == S_UPD) ? val_reg   : mem_rdata;

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            // a new result may replace the one taken in the same cycle
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    if (sweep_last)
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
                S_IDLE:
                begin
                    pend_reg <= 1'b0;
                    if (in_fire)
                    begin
                        unique case (req.cmd)
                            CMD_UPDATE:
                            begin
                                if (upd_ok)
                                begin
                                    pos_reg   <= POS_W'(idx_ext);
                                    state_reg <= S_UPD;
                                end
                            end
                            CMD_QUERY:
                            begin
                                pos_reg   <= POS_W'(qry_pos);
                                state_reg <= (qry_pos == 32'd0) ? S_RES : S_QRY;
                            end
                            CMD_CLEAR:
                            begin
                                pos_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_UPD:
                begin
                    // read next node while the previous one is written back
                    pend_reg <= !pos_done;
                    if (!pos_done)
                    begin
                        pos_reg <= pos_reg + pos_low;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_QRY:
                begin
                    pend_reg <= (pos_reg != '0);
                    if (pos_reg != '0)
                    begin
                        pos_reg <= pos_reg - pos_low;
                    end
                    else
                    begin
                        state_reg <= S_RES;
                    end
                end
                S_RES:
                begin
                    if (res_load)
                    begin
                        result_reg <= acc_reg;
                        state_reg  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            val_reg <= req.value;
            acc_reg <= cfg.identity_value;
        end
        else if ((state_reg == S_QRY) && pend_reg)
        begin
            acc_reg <= fold_out;
        end
        if ((state_reg == S_UPD) && !pos_done)
        begin
            node_addr_reg <= pos_reg[ADDR_W-1:0];
        end
    end

    // Checks
    `FPCT_ASSERT_IMPL(a_upd_no_node0, clk, rst_n,
        mem_we && (state_reg == S_UPD), node_addr_reg != '0,
        "update wrote node zero")
    `FPCT_ASSERT_NEXT(a_qry_zero_direct, clk, rst_n,
        in_fire && (req.cmd == CMD_QUERY) && (req.index == '0), state_reg == S_RES,
        "empty query did not go to result")
    `FPCT_ASSERT_NEXT(a_qry_descends, clk, rst_n,
        (state_reg == S_QRY) && (pos_reg != '0), pos_reg < $past(pos_reg),
        "query walk did not descend")
    `FPCT_ASSERT_NEXT(a_upd_ascends, clk, rst_n,
        (state_reg == S_UPD) && !pos_done, pos_reg > $past(pos_reg),
        "update walk did not ascend")
    `FPCT_ASSERT_IMPL(a_result_source, clk, rst_n,
        $rose(out_valid_reg), $past(state_reg) == S_RES,
        "result raised outside result state")

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the prefix-combine table (binary indexed tree)
`timescale 1ns / 100ps

module tb;
    import fpct_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [CMD_W-1:0]  CMD_NOP   = 2'd3;
    localparam logic [MODE_W-1:0] OP_SPARE  = 2'd3;

    localparam int RESET_CYCLES = 9;
    localparam int PHASE_ITEMS  = 110;
    localparam int DRAIN_CYCLES = TABLE_SIZE + 16;   // a clear may still be running
    localparam int TAIL_CYCLES  = 32;
    localparam int STALL_LIMIT  = 5000;

    // Directed stimulus row; typed rows carry their expected prefix
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] index;
        node_t            value;
        logic             typed;
        node_t            prefix;
    } dir_row_t;

    // Per-phase register setting
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        node_t             ident;
        logic              rand_ident;
        logic              fresh;      // open the phase with a clear
    } phase_cfg_t;

    localparam int DIR_N   = 23;
    localparam int PHASE_N = 8;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    fpct_req_if req_ch ();
    fpct_rsp_if rsp_ch ();

    // Shadow copy of the table and its registers
    node_t             shadow_nodes [TABLE_SIZE];
    logic [MODE_W-1:0] shadow_mode;
    node_t             shadow_ident;

    node_t prefix_q [$];
    int    err_cnt;
    int    stall_cnt;
    bit    calm;

    dir_row_t   dir_rows [DIR_N];
    phase_cfg_t phases [PHASE_N];

    fenwick_prefix_combine_table u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Fold two nodes under the current operator; the spare code adds
    function automatic node_t combine(input node_t a, input node_t b);
        case (shadow_mode)
            OP_MAX:  return (a < b) ? b : a;
            OP_MIN:  return (b < a) ? b : a;
            default: return a + b;
        endcase
    endfunction

    // Apply one item to the shadow table; returns 1 when a prefix comes back
    function automatic bit predict_item(input logic [CMD_W-1:0] cmd,
                                        input logic [IDX_W-1:0] idx,
                                        input node_t val,
                                        output node_t prefix);
        int pos;
        node_t acc;
        prefix = '0;
        pos = int'(idx);
        case (cmd)
            CMD_UPDATE:
            begin
                // walk up by the lowest set bit; index zero is a no-op
                if (pos != 0)
                begin
                    while (pos < TABLE_SIZE)
                    begin
                        shadow_nodes[pos] = combine(shadow_nodes[pos], val);
                        pos += pos & -pos;
                    end
                end
                return 1'b0;
            end
            CMD_QUERY:
            begin
                acc = shadow_ident;
                if (pos > TABLE_SIZE - 1)
                    pos = TABLE_SIZE - 1;
                while (pos != 0)
                begin
                    acc = combine(acc, shadow_nodes[pos]);
                    pos -= pos & -pos;
                end
                prefix = acc;
                return 1'b1;
            end
            CMD_CLEAR:
            begin
                foreach (shadow_nodes[i])
                    shadow_nodes[i] = shadow_ident;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // One APB transfer: setup then access, data sampled at the access edge
    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Wait for the block to go idle, then write and read back both registers
    task automatic set_config(input logic [MODE_W-1:0] mode, input node_t ident);
        logic [31:0] rd;
        req_ch.valid = 1'b0;
        while (prefix_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        reg_access(1'b1, {REG_OP_MODE, 2'b00}, {{(32 - MODE_W){1'b0}}, mode}, rd);
        reg_access(1'b1, {REG_IDENTITY, 2'b00}, ident, rd);
        shadow_mode  = mode;
        shadow_ident = ident;
        reg_access(1'b0, {REG_OP_MODE, 2'b00}, 32'd0, rd);
        if (rd[MODE_W-1:0] !== mode)
        begin
            $error("op_mode readback: expected %0d, actual %0d", mode, rd[MODE_W-1:0]);
            err_cnt++;
        end
        reg_access(1'b0, {REG_IDENTITY, 2'b00}, 32'd0, rd);
        if (rd !== ident)
        begin
            $error("identity_value readback: expected %0d, actual %0d", ident, $signed(rd));
            err_cnt++;
        end
    endtask

    // Drive one item, with an optional gap ahead of it, until it is taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input node_t val);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.cmd   = cmd;
        req_ch.index = idx;
        req_ch.value = val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // Send, predict and queue the expectation
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                         input node_t val, input logic typed, input node_t typed_prefix);
        node_t prefix;
        send_item(cmd, idx, val);
        if (predict_item(cmd, idx, val, prefix))
            prefix_q.push_back(typed ? typed_prefix : prefix);
    endtask

    // Random traffic: mostly updates and queries, rare clears and spare codes
    task automatic run_random(input bit fresh);
        int r;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        node_t val;
        if (fresh)
            issue(CMD_CLEAR, IDX_W'($urandom), node_t'($urandom), 1'b0, '0);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            // sender holds off until the block has answered everything
            if (n == PHASE_ITEMS / 2)
            begin
                while (prefix_q.size() != 0)
                    @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 2)
                cmd = CMD_CLEAR;
            else if (r < 5)
                cmd = CMD_NOP;
            else if (r < 52)
                cmd = CMD_UPDATE;
            else
                cmd = CMD_QUERY;
            case ($urandom_range(0, 9))
                0:       idx = '0;
                1:       idx = IDX_W'(TABLE_SIZE - 1);
                2:       idx = IDX_W'($urandom_range(1, 16));
                default: idx = IDX_W'($urandom_range(1, TABLE_SIZE - 1));
            endcase
            case ($urandom_range(0, 9))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7FFF_FFFF;
                2:       val = -32'sd1;
                3, 4, 5: val = node_t'($urandom_range(0, 200)) - 32'sd100;
                default: val = node_t'($urandom);
            endcase
            issue(cmd, idx, val, 1'b0, '0);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (prefix_q.size() == 0)
            begin
                $error("prefix_result: no expectation pending, actual %0d",
                       rsp_ch.prefix_result);
                err_cnt++;
            end
            else
            begin
                if (rsp_ch.prefix_result !== prefix_q[0])
                begin
                    $error("prefix_result: expected %0d, actual %0d",
                           prefix_q[0], rsp_ch.prefix_result);
                    err_cnt++;
                end
                void'(prefix_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts; none once the run turns calm
    initial
    begin
        int burst;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ch.ready = calm || ($urandom_range(0, 2) != 0);
            burst = $urandom_range(1, 16);
            repeat (burst) @(negedge clk);
        end
    end

    // Main sequence
    initial
    begin
        node_t ident;
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_UPDATE;
        req_ch.index = '0;
        req_ch.value = '0;
        err_cnt      = 0;
        stall_cnt    = 0;
        calm         = 1'b0;
        shadow_mode  = OP_SUM;
        shadow_ident = '0;
        foreach (shadow_nodes[i])
            shadow_nodes[i] = '0;

        // Directed rows run with the reset setting: wrapping sum, identity zero
        dir_rows = '{
            '{CMD_QUERY,  10'd0,    32'sd0,          1'b1, 32'sd0},
            '{CMD_QUERY,  10'd1023, 32'sd0,          1'b1, 32'sd0},
            '{CMD_UPDATE, 10'd0,    32'sd5,          1'b0, 32'sd0},  // ignored
            '{CMD_QUERY,  10'd1023, 32'sd0,          1'b1, 32'sd0},
            '{CMD_UPDATE, 10'd1,    32'sh7FFF_FFFF,  1'b0, 32'sd0},
            '{CMD_UPDATE, 10'd1,    32'sd1,          1'b0, 32'sd0},  // sum wraps
            '{CMD_QUERY,  10'd1,    32'sd0,          1'b1, 32'sh8000_0000},
            '{CMD_QUERY,  10'd0,    32'sd0,          1'b1, 32'sd0},
            '{CMD_UPDATE, 10'd1023, 32'shFFFF_FFFF,  1'b0, 32'sd0},
            '{CMD_QUERY,  10'd1023, 32'sd0,          1'b0, 32'sd0},
            '{CMD_UPDATE, 10'd512,  32'sh8000_0000,  1'b0, 32'sd0},
            '{CMD_QUERY,  10'd512,  32'sd0,          1'b0, 32'sd0},
            '{CMD_QUERY,  10'd511,  32'sd0,          1'b0, 32'sd0},
            '{CMD_NOP,    10'd1023, 32'shFFFF_FFFF,  1'b0, 32'sd0},  // spare command
            '{CMD_QUERY,  10'd1023, 32'sd0,          1'b0, 32'sd0},
            '{CMD_UPDATE, 10'd682,  32'sh5555_5555,  1'b0, 32'sd0},
            '{CMD_QUERY,  10'd341,  32'shAAAA_AAAA,  1'b0, 32'sd0},
            '{CMD_QUERY,  10'd1022, 32'sd0,          1'b0, 32'sd0},
            '{CMD_CLEAR,  10'd0,    32'sd0,          1'b0, 32'sd0},
            '{CMD_QUERY,  10'd1023, 32'sd0,          1'b1, 32'sd0},
            '{CMD_UPDATE, 10'd1023, 32'sh1234_5678,  1'b0, 32'sd0},
            '{CMD_QUERY,  10'd1023, 32'sd0,          1'b1, 32'sh1234_5678},
            '{CMD_QUERY,  10'd1022, 32'sd0,          1'b1, 32'sd0}
        };

        phases = '{
            '{OP_MAX,   32'sh8000_0000, 1'b0, 1'b1},
            '{OP_MIN,   32'sh7FFF_FFFF, 1'b0, 1'b1},
            '{OP_SPARE, 32'sd0,         1'b1, 1'b1},
            '{OP_SUM,   32'sh7FFF_FFFF, 1'b0, 1'b0},  // identity changes, nodes kept
            '{OP_MAX,   32'sd0,         1'b1, 1'b1},
            '{OP_MIN,   32'sd0,         1'b1, 1'b1},
            '{OP_MAX,   32'sd0,         1'b0, 1'b0},  // max over leftover nodes
            '{OP_SUM,   32'sd0,         1'b0, 1'b1}
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            issue(dir_rows[i].cmd, dir_rows[i].index, dir_rows[i].value,
                  dir_rows[i].typed, dir_rows[i].prefix);

        foreach (phases[p])
        begin
            ident = phases[p].rand_ident ? node_t'($urandom) : phases[p].ident;
            set_config(phases[p].mode, ident);
            if (p == PHASE_N - 1)
                calm = 1'b1;
            run_random(phases[p].fresh);
        end

        // Drain
        while (prefix_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (prefix_q.size() != 0)
        begin
            $error("prefix_result: %0d expectations never answered", prefix_q.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
